/* src/upe_pkg.sv */
// Package: shared types, codes and constants for the frame payload extractor.
`default_nettype none
package upe_pkg;

    localparam int LENGTH_BITS_DEFAULT = 16;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    localparam logic [7:0]  WANT_CLASS_RESET    = 8'd1;
    localparam logic [7:0]  WANT_MESSAGE_RESET  = 8'd7;
    localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd3000;

    typedef enum logic [1:0] {
        FUNC_BYTE  = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_START = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_PAYLOAD = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_TIMEOUT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CFG_WANT_CLASS    = 2'd0,
        CFG_WANT_MESSAGE  = 2'd1,
        CFG_TIMEOUT_TICKS = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_CLASS = 3'd2,
        PH_MSG   = 3'd3,
        PH_LENLO = 3'd4,
        PH_LENHI = 3'd5,
        PH_DATA  = 3'd6
    } phase_t;

    typedef struct packed {
        logic [7:0]  want_class;
        logic [7:0]  want_message;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [7:0]  payload_data;
        logic [15:0] byte_index;
        logic [15:0] frame_length;
        logic        last;
    } result_t;

endpackage
`default_nettype wire

/* src/upe_parser_core.sv */
// Frame parser core: arming, header hunt, length capture, payload indexing and timeout.
`default_nettype none
module upe_parser_core #(
    parameter int LENGTH_BITS = upe_pkg::LENGTH_BITS_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic [1:0]      func,
    input  wire logic [7:0]      rx_data,
    input  wire upe_pkg::cfg_t   cfg,
    output upe_pkg::result_t     res
);

    logic                   armed_reg;
    logic                   armed_next;
    upe_pkg::phase_t        phase_reg;
    upe_pkg::phase_t        phase_next;
    logic [LENGTH_BITS-1:0] length_reg;
    logic [LENGTH_BITS-1:0] length_next;
    logic [LENGTH_BITS-1:0] count_reg;
    logic [LENGTH_BITS-1:0] count_next;
    logic [15:0]            elapsed_reg;
    logic [15:0]            elapsed_next;

    logic [16:0]            tick_sum;
    logic [LENGTH_BITS:0]   count_inc;
    logic [15:0]            low16;
    logic [15:0]            full16;
    logic [15:0]            index16;
    logic [15:0]            length16;
    logic [LENGTH_BITS-1:0] header_length;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg   <= 1'b0;
            phase_reg   <= upe_pkg::PH_SYNC1;
            length_reg  <= '0;
            count_reg   <= '0;
            elapsed_reg <= '0;
        end
        else if (step)
        begin
            armed_reg   <= armed_next;
            phase_reg   <= phase_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            elapsed_reg <= elapsed_next;
        end
    end

    always_comb
    begin
        tick_sum      = {1'b0, elapsed_reg} + 17'd1;
        count_inc     = {1'b0, count_reg} + {{LENGTH_BITS{1'b0}}, 1'b1};
        low16         = {8'h00, rx_data};
        full16        = {rx_data, length_reg[7:0]};
        header_length = full16[LENGTH_BITS-1:0];
        index16       = '0;
        index16[LENGTH_BITS-1:0] = count_reg;
        length16      = '0;
        length16[LENGTH_BITS-1:0] = length_reg;

        armed_next   = armed_reg;
        phase_next   = phase_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        elapsed_next = elapsed_reg;

        res              = '0;
        res.status       = upe_pkg::ST_PAYLOAD;

        if (func == upe_pkg::FUNC_START)
        begin
            armed_next   = 1'b1;
            phase_next   = upe_pkg::PH_SYNC1;
            length_next  = '0;
            count_next   = '0;
            elapsed_next = '0;
        end
        else if (armed_reg && func == upe_pkg::FUNC_TICK)
        begin
            if (tick_sum > {1'b0, cfg.timeout_ticks})
            begin
                armed_next = 1'b0;
                res.valid  = 1'b1;
                res.status = upe_pkg::ST_TIMEOUT;
                res.last   = 1'b1;
            end
            else
            begin
                elapsed_next = tick_sum[15:0];
            end
        end
        else if (armed_reg && func == upe_pkg::FUNC_BYTE)
        begin
            unique case (phase_reg)
                upe_pkg::PH_SYNC1:
                    phase_next = (rx_data == upe_pkg::SYNC_FIRST) ?
                                 upe_pkg::PH_SYNC2 : upe_pkg::PH_SYNC1;
                upe_pkg::PH_SYNC2:
                    phase_next = (rx_data == upe_pkg::SYNC_SECOND) ?
                                 upe_pkg::PH_CLASS : upe_pkg::PH_SYNC1;
                upe_pkg::PH_CLASS:
                    phase_next = (rx_data == cfg.want_class) ?
                                 upe_pkg::PH_MSG : upe_pkg::PH_SYNC1;
                upe_pkg::PH_MSG:
                    phase_next = (rx_data == cfg.want_message) ?
                                 upe_pkg::PH_LENLO : upe_pkg::PH_SYNC1;
                upe_pkg::PH_LENLO:
                begin
                    length_next = low16[LENGTH_BITS-1:0];
                    phase_next  = upe_pkg::PH_LENHI;
                end
                upe_pkg::PH_LENHI:
                begin
                    length_next = header_length;
                    count_next  = '0;
                    if (header_length == '0)
                    begin
                        armed_next = 1'b0;
                        phase_next = upe_pkg::PH_SYNC1;
                        res.valid  = 1'b1;
                        res.status = upe_pkg::ST_EMPTY;
                        res.last   = 1'b1;
                    end
                    else
                    begin
                        phase_next = upe_pkg::PH_DATA;
                    end
                end
                upe_pkg::PH_DATA:
                begin
                    res.valid        = 1'b1;
                    res.status       = upe_pkg::ST_PAYLOAD;
                    res.payload_data = rx_data;
                    res.byte_index   = index16;
                    res.frame_length = length16;
                    res.last         = (count_inc >= {1'b0, length_reg});
                    count_next       = count_inc[LENGTH_BITS-1:0];
                    if (count_inc >= {1'b0, length_reg})
                    begin
                        armed_next = 1'b0;
                        phase_next = upe_pkg::PH_SYNC1;
                    end
                end
                default:
                    phase_next = upe_pkg::PH_SYNC1;
            endcase
        end
    end

endmodule
`default_nettype wire

/* src/ubx_payload_extractor_top.sv */
// Top level: configuration registers, request handshake and result register.
//
// Requests arrive on the input channel (in_valid/in_ready) carrying func and
// rx_data: a start request arms the search, byte requests step the header
// hunt and payload extraction, tick requests count towards the timeout.
// Results leave on the output channel (out_valid/out_ready): one result per
// payload byte, one for an empty frame, or one for a timeout.
// A request's result is registered in the output register at the edge that
// accepts it. Requests are taken one per cycle while in_ready is high, each
// stepping the parser state once.
// in_ready is high while the output register is empty or being drained, so
// a stalled receiver holds the current result and stops new requests only
// once that register is full; nothing is lost or repeated.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the next
// edge; the user makes them only while the block is idle (the block has no check).
// Reset disarms the parser, empties the output register and restores the
// configuration defaults: class 1, message 7, timeout 3000 ticks.
`default_nettype none
module ubx_payload_extractor_top #(
    parameter int LENGTH_BITS = upe_pkg::LENGTH_BITS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  rx_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [7:0]       payload_data,
    output logic [15:0]      byte_index,
    output logic [15:0]      frame_length,
    output logic             last
);

    upe_pkg::cfg_t    cfg_reg;
    upe_pkg::result_t res;
    logic             step;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [1:0]       status_reg;
    logic [7:0]       payload_data_reg;
    logic [15:0]      byte_index_reg;
    logic [15:0]      frame_length_reg;
    logic             last_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.want_class    <= upe_pkg::WANT_CLASS_RESET;
            cfg_reg.want_message  <= upe_pkg::WANT_MESSAGE_RESET;
            cfg_reg.timeout_ticks <= upe_pkg::TIMEOUT_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                upe_pkg::CFG_WANT_CLASS:    cfg_reg.want_class    <= cfg_data[7:0];
                upe_pkg::CFG_WANT_MESSAGE:  cfg_reg.want_message  <= cfg_data[7:0];
                upe_pkg::CFG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_data;
                default: ;
            endcase
        end
    end

    upe_parser_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .func    (func),
        .rx_data (rx_data),
        .cfg     (cfg_reg),
        .res     (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (step)
        begin
            out_valid_next = res.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res.valid)
        begin
            status_reg       <= res.status;
            payload_data_reg <= res.payload_data;
            byte_index_reg   <= res.byte_index;
            frame_length_reg <= res.frame_length;
            last_reg         <= res.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign payload_data = payload_data_reg;
    assign byte_index   = byte_index_reg;
    assign frame_length = frame_length_reg;
    assign last         = last_reg;

endmodule
`default_nettype wire

/* dv/ubx_payload_extractor_top_tb.sv */
// Testbench for the frame payload extractor: directed table, random frames, scoreboard.
module ubx_payload_extractor_top_tb;

    localparam int          LEN_BITS    = upe_pkg::LENGTH_BITS_DEFAULT;
    localparam logic [15:0] LEN_MASK    = 16'((32'd1 << LEN_BITS) - 1);
    localparam logic [1:0]  FUNC_SPARE  = 2'd3;
    localparam int          STALL_LIMIT = 2000;
    localparam int          TAIL_CYCLES = 8;
    localparam int          DIR_ROWS    = 28;
    localparam int          PHASES      = 8;
    localparam int          PHASE_ITEMS = 135;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_FIXED
    } check_e;

    typedef struct packed {
        upe_pkg::status_t status;
        logic [7:0]       data;
        logic [15:0]      index;
        logic [15:0]      length;
        logic             last;
    } outcome_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data;
        check_e     chk;
        outcome_t   res;
    } row_t;

    localparam outcome_t RES_EMPTY   = '{upe_pkg::ST_EMPTY, 8'h00, 16'd0, 16'd0, 1'b1};
    localparam outcome_t RES_TIMEOUT = '{upe_pkg::ST_TIMEOUT, 8'h00, 16'd0, 16'd0, 1'b1};

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic [7:0]  rx_data;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [7:0]  payload_data;
    logic [15:0] byte_index;
    logic [15:0] frame_length;
    logic        last;

    ubx_payload_extractor_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .rx_data      (rx_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .payload_data (payload_data),
        .byte_index   (byte_index),
        .frame_length (frame_length),
        .last         (last)
    );

    // parser copy
    logic [7:0]       class_q   = upe_pkg::WANT_CLASS_RESET;
    logic [7:0]       message_q = upe_pkg::WANT_MESSAGE_RESET;
    logic [15:0]      timeout_q = upe_pkg::TIMEOUT_TICKS_RESET;
    logic             armed_q   = 1'b0;
    upe_pkg::phase_t  phase_q   = upe_pkg::PH_SYNC1;
    logic [15:0]      length_q  = '0;
    logic [15:0]      count_q   = '0;
    logic [15:0]      elapsed_q = '0;

    outcome_t    extracted_q[$];
    check_e      pin_chk;
    outcome_t    pin_res;
    bit          calm;
    int          sent;
    int          bad_results  = 0;
    int          quiet_cycles = 0;
    int          ready_left;
    row_t        plan [0:DIR_ROWS-1];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit parse_step(input logic [1:0] f, input logic [7:0] b,
                                      output outcome_t o);
        logic [16:0] next_ticks;
        bit          fin;
        o = '0;
        if (f == upe_pkg::FUNC_START)
        begin
            armed_q   = 1'b1;
            phase_q   = upe_pkg::PH_SYNC1;
            length_q  = '0;
            count_q   = '0;
            elapsed_q = '0;
            return 1'b0;
        end
        if (!armed_q || f == FUNC_SPARE)
            return 1'b0;
        if (f == upe_pkg::FUNC_TICK)
        begin
            next_ticks = {1'b0, elapsed_q} + 17'd1;
            if (next_ticks > {1'b0, timeout_q})
            begin
                armed_q  = 1'b0;
                o.status = upe_pkg::ST_TIMEOUT;
                o.last   = 1'b1;
                return 1'b1;
            end
            elapsed_q = next_ticks[15:0];
            return 1'b0;
        end
        case (phase_q)
            upe_pkg::PH_SYNC1:
                phase_q = (b == upe_pkg::SYNC_FIRST) ? upe_pkg::PH_SYNC2 : upe_pkg::PH_SYNC1;
            upe_pkg::PH_SYNC2:
                phase_q = (b == upe_pkg::SYNC_SECOND) ? upe_pkg::PH_CLASS : upe_pkg::PH_SYNC1;
            upe_pkg::PH_CLASS:
                phase_q = (b == class_q) ? upe_pkg::PH_MSG : upe_pkg::PH_SYNC1;
            upe_pkg::PH_MSG:
                phase_q = (b == message_q) ? upe_pkg::PH_LENLO : upe_pkg::PH_SYNC1;
            upe_pkg::PH_LENLO:
            begin
                length_q = {8'h00, b} & LEN_MASK;
                phase_q  = upe_pkg::PH_LENHI;
            end
            upe_pkg::PH_LENHI:
            begin
                length_q = (length_q | {b, 8'h00}) & LEN_MASK;
                count_q  = '0;
                if (length_q == '0)
                begin
                    armed_q  = 1'b0;
                    phase_q  = upe_pkg::PH_SYNC1;
                    o.status = upe_pkg::ST_EMPTY;
                    o.last   = 1'b1;
                    return 1'b1;
                end
                phase_q = upe_pkg::PH_DATA;
            end
            upe_pkg::PH_DATA:
            begin
                fin      = ({1'b0, count_q} + 17'd1) >= {1'b0, length_q};
                o.status = upe_pkg::ST_PAYLOAD;
                o.data   = b;
                o.index  = count_q;
                o.length = length_q;
                o.last   = fin;
                count_q  = count_q + 16'd1;
                if (fin)
                begin
                    armed_q = 1'b0;
                    phase_q = upe_pkg::PH_SYNC1;
                end
                return 1'b1;
            end
            default: phase_q = upe_pkg::PH_SYNC1;
        endcase
        return 1'b0;
    endfunction

    function automatic void flag(input string what, input outcome_t want,
                                 input outcome_t got);
        bad_results++;
        if (bad_results <= 10)
        begin
            $write("%s: expected st=%0d data=%h idx=%0d len=%0d last=%b, ",
                   what, want.status, want.data, want.index, want.length, want.last);
            $display("got st=%0d data=%h idx=%0d len=%0d last=%b",
                     got.status, got.data, got.index, got.length, got.last);
        end
    endfunction

    always @(posedge clk)
    begin
        outcome_t guess;
        outcome_t got;
        outcome_t want;
        bit       hit;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    upe_pkg::CFG_WANT_CLASS:    class_q   = cfg_data[7:0];
                    upe_pkg::CFG_WANT_MESSAGE:  message_q = cfg_data[7:0];
                    upe_pkg::CFG_TIMEOUT_TICKS: timeout_q = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                got.status = upe_pkg::status_t'(status);
                got.data   = payload_data;
                got.index  = byte_index;
                got.length = frame_length;
                got.last   = last;
                if (extracted_q.size() == 0)
                    flag("unexpected result", '0, got);
                else
                begin
                    want = extracted_q.pop_front();
                    if (got !== want)
                        flag("mismatch", want, got);
                end
            end
            if (in_valid && in_ready)
            begin
                hit = parse_step(func, rx_data, guess);
                if (pin_chk == CHK_FIXED)
                    extracted_q.push_back(pin_res);
                else if (pin_chk == CHK_MODEL && hit)
                    extracted_q.push_back(guess);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        out_ready  = 1'b0;
        ready_left = 0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                out_ready = 1'b0;
            else if (calm)
                out_ready = 1'b1;
            else if (ready_left > 0)
                ready_left--;
            else if (out_ready)
            begin
                out_ready  = 1'b0;
                ready_left = $urandom_range(1, 18) - 1;
            end
            else
            begin
                out_ready  = 1'b1;
                ready_left = $urandom_range(0, 40);
            end
        end
    end

    task automatic drive(input logic [1:0] f, input logic [7:0] b, input check_e chk,
                         input outcome_t res);
        func     = f;
        rx_data  = b;
        pin_chk  = chk;
        pin_res  = res;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        @(negedge clk);
        sent++;
    endtask

    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid = 1'b0;
            func     = 2'($urandom);
            rx_data  = 8'($urandom);
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
    endtask

    task automatic put(input logic [1:0] f, input logic [7:0] b);
        maybe_gap();
        drive(f, b, CHK_MODEL, '0);
    endtask

    task automatic maybe_tick();
        if ($urandom_range(0, 11) == 0)
            put(upe_pkg::FUNC_TICK, 8'($urandom));
    endtask

    // hold off until the output side is empty and the parser has gone quiet
    task automatic settle();
        in_valid = 1'b0;
        while (extracted_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input upe_pkg::cfg_index_t idx, input logic [15:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic send_frame(input bit good);
        logic [7:0]  hdr [4];
        logic [7:0]  b;
        logic [15:0] len;
        int          spoil;
        int          cut;
        int          pick;
        hdr[0] = upe_pkg::SYNC_FIRST;
        hdr[1] = upe_pkg::SYNC_SECOND;
        hdr[2] = class_q;
        hdr[3] = message_q;
        spoil  = good ? 0 : $urandom_range(1, 4);
        if ($urandom_range(0, 9) != 0)
            put(upe_pkg::FUNC_START, 8'($urandom));
        for (int i = 0; i < 4; i++)
        begin
            b = hdr[i];
            if (spoil == i + 1)
                b = hdr[i] ^ 8'($urandom_range(1, 255));
            put(upe_pkg::FUNC_BYTE, b);
            maybe_tick();
        end
        pick = $urandom_range(0, 99);
        if (pick < 10)
            len = 16'd0;
        else if (pick < 85)
            len = 16'($urandom_range(1, 8));
        else if (pick < 95)
            len = 16'($urandom_range(9, 40));
        else
            len = {($urandom_range(0, 1) != 0) ? 8'hFF : 8'($urandom), 8'($urandom)};
        // truncate long frames; the next start cuts them off
        cut = (len > 16'd40) ? $urandom_range(1, 6) : int'(len);
        put(upe_pkg::FUNC_BYTE, len[7:0]);
        put(upe_pkg::FUNC_BYTE, len[15:8]);
        for (int i = 0; i < cut; i++)
        begin
            maybe_tick();
            put(upe_pkg::FUNC_BYTE, 8'($urandom));
        end
        put(upe_pkg::FUNC_BYTE, 8'($urandom));
        put(upe_pkg::FUNC_BYTE, 8'($urandom));
    endtask

    task automatic run_phase(input int budget);
        int stop;
        int kind;
        stop = sent + budget;
        while (sent < stop)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 65)
                send_frame(1'b1);
            else if (kind < 80)
                send_frame(1'b0);
            else if (kind < 95)
                repeat ($urandom_range(1, 6))
                    put(2'($urandom_range(0, 3)), 8'($urandom));
            else if (!calm)
            begin
                in_valid = 1'b0;
                while (extracted_q.size() != 0)
                    @(negedge clk);
            end
        end
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = upe_pkg::CFG_WANT_CLASS;
        cfg_data     = '0;
        in_valid     = 1'b0;
        func         = upe_pkg::FUNC_BYTE;
        rx_data      = '0;
        pin_chk      = CHK_MODEL;
        pin_res      = '0;
        calm         = 1'b0;
        sent         = 0;

        plan = '{
            '{upe_pkg::FUNC_BYTE,  8'hB5, CHK_NONE,  '0},
            '{upe_pkg::FUNC_TICK,  8'h00, CHK_NONE,  '0},
            '{FUNC_SPARE,          8'hFF, CHK_NONE,  '0},
            '{upe_pkg::FUNC_START, 8'h00, CHK_NONE,  '0},
            '{FUNC_SPARE,          8'hFF, CHK_NONE,  '0},
            '{upe_pkg::FUNC_BYTE,  8'hB5, CHK_MODEL, '0},
            '{upe_pkg::FUNC_BYTE,  8'hB5, CHK_MODEL, '0},
            '{upe_pkg::FUNC_BYTE,  8'h62, CHK_MODEL, '0},
            '{upe_pkg::FUNC_BYTE,  8'hB5, CHK_MODEL, '0},
            '{upe_pkg::FUNC_BYTE,  8'h62, CHK_MODEL, '0},
            '{upe_pkg::FUNC_BYTE,  8'h01, CHK_MODEL, '0},
            '{upe_pkg::FUNC_BYTE,  8'h07, CHK_MODEL, '0},
            '{upe_pkg::FUNC_BYTE,  8'h00, CHK_MODEL, '0},
            '{upe_pkg::FUNC_BYTE,  8'h00, CHK_FIXED, RES_EMPTY},
            '{upe_pkg::FUNC_START, 8'hFF, CHK_NONE,  '0},
            '{upe_pkg::FUNC_BYTE,  8'hB5, CHK_MODEL, '0},
            '{upe_pkg::FUNC_BYTE,  8'h62, CHK_MODEL, '0},
            '{upe_pkg::FUNC_BYTE,  8'h01, CHK_MODEL, '0},
            '{upe_pkg::FUNC_BYTE,  8'h07, CHK_MODEL, '0},
            '{upe_pkg::FUNC_BYTE,  8'h02, CHK_MODEL, '0},
            '{upe_pkg::FUNC_BYTE,  8'h00, CHK_MODEL, '0},
            '{upe_pkg::FUNC_BYTE,  8'hFF, CHK_MODEL, '0},
            '{upe_pkg::FUNC_BYTE,  8'h00, CHK_MODEL, '0},
            '{upe_pkg::FUNC_START, 8'h00, CHK_NONE,  '0},
            '{upe_pkg::FUNC_TICK,  8'h00, CHK_NONE,  '0},
            '{upe_pkg::FUNC_TICK,  8'hFF, CHK_NONE,  '0},
            '{upe_pkg::FUNC_TICK,  8'h00, CHK_FIXED, RES_TIMEOUT},
            '{upe_pkg::FUNC_BYTE,  8'h7E, CHK_NONE,  '0}
        };

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_reg(upe_pkg::CFG_TIMEOUT_TICKS, 16'd2);
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            maybe_gap();
            drive(plan[i].func, plan[i].data, plan[i].chk, plan[i].res);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            calm = (p == PHASES - 1);
            case (p % 4)
                0:
                begin
                    write_reg(upe_pkg::CFG_WANT_CLASS, 16'h0000);
                    write_reg(upe_pkg::CFG_WANT_MESSAGE, 16'h00FF);
                end
                1:
                begin
                    write_reg(upe_pkg::CFG_WANT_CLASS, 16'h00FF);
                    write_reg(upe_pkg::CFG_WANT_MESSAGE, 16'h0000);
                end
                default:
                begin
                    write_reg(upe_pkg::CFG_WANT_CLASS, 16'($urandom));
                    write_reg(upe_pkg::CFG_WANT_MESSAGE, 16'($urandom));
                end
            endcase
            case (p)
                0:       write_reg(upe_pkg::CFG_TIMEOUT_TICKS, 16'd0);
                1:       write_reg(upe_pkg::CFG_TIMEOUT_TICKS, 16'hFFFF);
                2:       write_reg(upe_pkg::CFG_TIMEOUT_TICKS, 16'($urandom_range(1, 20)));
                3:       write_reg(upe_pkg::CFG_TIMEOUT_TICKS, 16'd3000);
                4:       write_reg(upe_pkg::CFG_TIMEOUT_TICKS, 16'($urandom));
                default: write_reg(upe_pkg::CFG_TIMEOUT_TICKS, 16'($urandom_range(5, 60)));
            endcase
            run_phase(PHASE_ITEMS);
        end

        in_valid = 1'b0;
        while (extracted_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (bad_results == 0 && extracted_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
